FILE: hw/rtl/dbl_pkg.sv
// Shared types and constants of the two-button debouncer with long press.
// Used by the front, queue, back, top level and checker modules.
`default_nettype none

package dbl_pkg;

   // Field and register widths
   localparam int STAMP_W = 32;
   localparam int DEB_W   = 16;
   localparam int LONG_W  = 24;
   localparam int BUDG_W  = 3;
   localparam int CNT_W   = 3;
   localparam int EVT_CAP = 4;
   localparam int SLOT_W  = 2;

   // Configuration register indexes
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_LONG     = 1'b1;

   // Reset values of the configuration registers
   localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(50);
   localparam logic [LONG_W-1:0] LONG_RESET = LONG_W'(1000);

   // Event kinds
   localparam logic [1:0] ACT_DOWN    = 2'd0;
   localparam logic [1:0] ACT_UP      = 2'd1;
   localparam logic [1:0] ACT_PRESSED = 2'd2;
   localparam logic [1:0] ACT_LONG    = 2'd3;

   localparam logic [BUDG_W-1:0] BUDGET_CAP = BUDG_W'(EVT_CAP);

   typedef struct packed {
      logic [STAMP_W-1:0] now_ms;
      logic               raw_primary;
      logic               raw_secondary;
      logic [BUDG_W-1:0]  max_events;
   } req_type;

   typedef struct packed {
      logic       button_id;
      logic [1:0] action;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       button_id;
      logic [1:0] action;
   } evt_type;

   // Events of one poll, already cut to the budget
   typedef struct packed {
      evt_type [EVT_CAP-1:0] evts;
      logic [CNT_W-1:0]      count;
   } bundle_type;

endpackage

`default_nettype wire

FILE: hw/rtl/button_debounce_long_press.sv
// The bundle of a poll is first written into the queue, and its first event is then
// loaded into the output register. A poll is taken every cycle while the bundle queue
// has room; a poll with no events takes no room. The back part sends one event per
// cycle while the output is not stalled.
// Reset clears the button state and the queue and restores the debounce window to 50
// and the long-press time to 1000. Depends on dbl_pkg, dbl_front, dbl_queue, dbl_back.
`default_nettype none

module button_debounce_long_press
   import dbl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_addr,
   input  wire logic [LONG_W-1:0] csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data
);

   logic       q_full;
   logic       q_push;
   bundle_type q_bundle;
   logic       head_valid;
   bundle_type head_bundle;
   logic       q_pop;

   dbl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_bundle  (q_bundle)
   );

   dbl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (q_bundle),
      .full        (q_full),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (q_pop)
   );

   dbl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/dbl_front.sv
// Front part: configuration registers, per-button debounce state and
// classification of each poll into a bundle of events. Uses dbl_pkg.
`default_nettype none

module dbl_front
   import dbl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_addr,
   input  wire logic [LONG_W-1:0] csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   input  wire logic              q_full,
   output logic                   q_push,
   output bundle_type             q_bundle
);

   logic [DEB_W-1:0]   deb_ff,   deb_in;
   logic [LONG_W-1:0]  long_ff,  long_in;
   logic [1:0]         level_ff, level_in;
   logic [1:0]         fired_ff, fired_in;
   logic [STAMP_W-1:0] chg_ff [2];
   logic [STAMP_W-1:0] chg_in [2];
   logic [STAMP_W-1:0] prs_ff [2];
   logic [STAMP_W-1:0] prs_in [2];

   evt_type    ev0 [2];
   evt_type    ev1 [2];
   logic [1:0] nev [2];
   logic [1:0] raw;
   logic       accept;
   logic [CNT_W-1:0]  total;
   logic [BUDG_W-1:0] budget;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign raw       = {req_data.raw_secondary, req_data.raw_primary};

   // Write configuration
   always_comb begin
      deb_in  = deb_ff;
      long_in = long_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_DEBOUNCE: deb_in  = csr_wdata[DEB_W-1:0];
            CSR_LONG:     long_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   // Evaluate each button: accepted change, then long-press check
   for (genvar b = 0; b < 2; b++) begin : g_btn
      logic [STAMP_W-1:0] dchg;
      logic [STAMP_W-1:0] dprs;
      logic               chg_ok;
      logic               long_ok;

      assign dchg    = req_data.now_ms - chg_ff[b];
      assign dprs    = req_data.now_ms - prs_ff[b];
      assign chg_ok  = (raw[b] != level_ff[b]) && (dchg >= STAMP_W'(deb_ff));
      assign long_ok = level_ff[b] && !fired_ff[b] && (dprs >= STAMP_W'(long_ff));

      always_comb begin
         level_in[b] = level_ff[b];
         fired_in[b] = fired_ff[b];
         chg_in[b]   = chg_ff[b];
         prs_in[b]   = prs_ff[b];
         ev0[b]      = '{button_id: 1'(b), action: ACT_DOWN};
         ev1[b]      = '{button_id: 1'(b), action: ACT_LONG};
         nev[b]      = 2'd0;
         if (chg_ok) begin
            level_in[b] = raw[b];
            chg_in[b]   = req_data.now_ms;
            if (raw[b]) begin
               // press: timer restarts, zero long time fires at once
               prs_in[b]   = req_data.now_ms;
               ev0[b].action = ACT_DOWN;
               ev1[b].action = ACT_LONG;
               if (long_ff == '0) begin
                  fired_in[b] = 1'b1;
                  nev[b]      = 2'd2;
               end else begin
                  fired_in[b] = 1'b0;
                  nev[b]      = 2'd1;
               end
            end else begin
               // release: click only if no long press was reported
               ev0[b].action = ACT_UP;
               ev1[b].action = ACT_PRESSED;
               nev[b]        = fired_ff[b] ? 2'd1 : 2'd2;
            end
         end else if (long_ok) begin
            fired_in[b]   = 1'b1;
            ev0[b].action = ACT_LONG;
            nev[b]        = 2'd1;
         end
      end
   end

   // Pack button 0 events ahead of button 1 events, cut to the budget
   always_comb begin
      budget = (req_data.max_events > BUDGET_CAP) ? BUDGET_CAP : req_data.max_events;
      total  = CNT_W'(nev[0]) + CNT_W'(nev[1]);
      q_bundle.count   = (total > budget) ? budget : total;
      q_bundle.evts[0] = (nev[0] != 2'd0) ? ev0[0] : ev0[1];
      case (nev[0])
         2'd2:    q_bundle.evts[1] = ev1[0];
         2'd1:    q_bundle.evts[1] = ev0[1];
         default: q_bundle.evts[1] = ev1[1];
      endcase
      q_bundle.evts[2] = (nev[0] == 2'd2) ? ev0[1] : ev1[1];
      q_bundle.evts[3] = ev1[1];
   end

   assign q_push = accept && (q_bundle.count != '0);

   // Hold configuration and button state
   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff   <= DEB_RESET;
         long_ff  <= LONG_RESET;
         level_ff <= '0;
         fired_ff <= '0;
         chg_ff   <= '{default: '0};
         prs_ff   <= '{default: '0};
      end else begin
         deb_ff  <= deb_in;
         long_ff <= long_in;
         if (accept) begin
            level_ff <= level_in;
            fired_ff <= fired_in;
            chg_ff   <= chg_in;
            prs_ff   <= prs_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dbl_queue.sv
// Short queue of event bundles between the front and back parts.
// Uses dbl_pkg for the bundle type.
`default_nettype none

module dbl_queue
   import dbl_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_bundle,
   output logic            full,
   output logic            head_valid,
   output bundle_type      head_bundle,
   input  wire logic       pop
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   bundle_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff,   fill_in;
   logic               do_push;
   logic               do_pop;

   assign full        = (fill_ff == FILL_W'(DEPTH));
   assign head_valid  = (fill_ff != '0);
   assign head_bundle = mem_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && head_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store bundle
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dbl_back.sv
// Back part: walks the head bundle one event per cycle into the output
// register while it is free, and marks the final event of each poll. Uses dbl_pkg.
`default_nettype none

module dbl_back
   import dbl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire bundle_type head_bundle,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              valid_ff, valid_in;
   rsp_type           data_ff, data_in;
   logic              out_free;
   logic              load;
   logic              is_last;
   evt_type           ev;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = head_valid && out_free;
   assign ev       = head_bundle.evts[slot_ff];
   assign is_last  = (CNT_W'(slot_ff) + 1'b1) == head_bundle.count;
   assign pop      = load && is_last;

   // Advance slot, load output register
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         slot_in  = is_last ? '0 : slot_ff + 1'b1;
         valid_in = 1'b1;
         data_in  = '{button_id: ev.button_id, action: ev.action, last: is_last};
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dbl_checker.sv
// Port-level checks of the debouncer, bound to the top level.
// Uses dbl_pkg for the event codes.
`default_nettype none

module dbl_checker
   import dbl_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   logic       rsp_fire;
   logic       prev_btn_ff;
   logic [1:0] prev_act_ff;
   logic       prev_last_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   // Hold the previous delivered event
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_btn_ff  <= 1'b0;
         prev_act_ff  <= ACT_DOWN;
         prev_last_ff <= 1'b1;
      end else if (rsp_fire) begin
         prev_btn_ff  <= rsp_data.button_id;
         prev_act_ff  <= rsp_data.action;
         prev_last_ff <= rsp_data.last;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_click_after_up: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (rsp_data.action == ACT_PRESSED) |->
         (prev_act_ff == ACT_UP) && (prev_btn_ff == rsp_data.button_id) && !prev_last_ff)
      else $error("click event not right after its release in the same poll");

   a_first_after_accept: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) && !$past(req_valid && req_ready)
         |=> !rsp_valid)
      else $error("result appeared without a recent poll");

endmodule

bind button_debounce_long_press dbl_checker u_dbl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
